### src/assert_macros.svh
// assertion macros used by the unpacker top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication under clock and active-low reset
`define SBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under clock and active-low reset
`define SBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/sbu_pkg.sv
// types and constants of the sample block unpacker
package sbu_pkg;

    localparam int RAM_WORDS     = 32;
    localparam int RAM_AW        = 6;
    localparam int RAM_DW        = 40;

    localparam logic [9:0] POS_STEP_BYTE = 10'd0;
    localparam logic [9:0] POS_ADDR_LO   = 10'd1;
    localparam logic [9:0] POS_ADDR_MID  = 10'd2;
    localparam logic [9:0] POS_ADDR_HI   = 10'd3;
    localparam logic [9:0] POS_HDR_LAST  = 10'd15;
    localparam logic [9:0] POS_GRP_FIRST = 10'd16;
    localparam logic [9:0] POS_GRP_END   = 10'd1000;

    localparam logic [7:0] OFF_DATA_END  = 8'd160;
    localparam logic [7:0] OFF_LAST      = 8'd163;
    localparam logic [2:0] SUB_LAST      = 3'd4;
    localparam logic [1:0] FLAG_LAST     = 2'd3;
    localparam logic [4:0] IDX_LAST      = 5'd31;

    localparam logic [2:0] REG_USE_SCALE_FLAGS = 3'd0;

    typedef enum logic [1:0] {
        CODE_SHIFT2 = 2'd0,
        CODE_SHIFT1 = 2'd1,
        CODE_KEEP_A = 2'd2,
        CODE_KEEP_B = 2'd3
    } scale_code_t;

    typedef struct packed {
        logic                en;
        logic [RAM_AW-1:0]   addr;
        logic [RAM_DW-1:0]   data;
    } ram_wr_t;

    typedef struct packed {
        logic                en;
        logic [RAM_AW-1:0]   addr;
    } ram_rd_t;

endpackage

### src/sbu_group_ram.sv
// double-buffered group ram, one 40-bit word per five packed bytes
module sbu_group_ram (
    input  logic                       clk,
    input  sbu_pkg::ram_wr_t           wr,
    input  sbu_pkg::ram_rd_t           rd,
    output logic [sbu_pkg::RAM_DW-1:0] rdata
);

    logic [sbu_pkg::RAM_DW-1:0] mem [2*sbu_pkg::RAM_WORDS];
    logic [sbu_pkg::RAM_DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/sdr_sample_block_unpacker.sv
// sample block unpacker top level: header check, group buffering and sample output
// Takes one stream byte per cycle while byte_stall is low. Packed group bytes are
// collected five at a time into 40-bit words of a two-bank group ram, so one group
// can be emptied while the next fills. The fourth flag byte of a group hands its
// bank to the output side, which reads one ram word per cycle and sends 32 items
// of four scaled samples at one item per cycle while result_stall is low, via the
// read and output registers. byte_stall rises only while both banks hold groups
// not yet sent; with an unstalled output the input sustains one byte per cycle.
module sdr_sample_block_unpacker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    input  logic               packet_start,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] sample_0,
    output logic signed [15:0] sample_1,
    output logic signed [15:0] sample_2,
    output logic signed [15:0] sample_3,
    output logic               gap_seen,
    output logic               last_of_group
);

    `include "assert_macros.svh"

    function automatic logic signed [15:0] scale_sample(input logic [15:0] raw,
                                                        input logic [1:0] code);
        logic signed [15:0] s;
        logic signed [15:0] r;
        s = $signed(raw);
        unique case (sbu_pkg::scale_code_t'(code))
            sbu_pkg::CODE_SHIFT2: r = s >>> 2;
            sbu_pkg::CODE_SHIFT1: r = s >>> 1;
            default:              r = s;
        endcase
        return r;
    endfunction

    logic        use_flags_reg;

    logic [9:0]  pos_reg, pos_next, pos_cur;
    logic [7:0]  off_reg, off_next;
    logic [2:0]  sub_reg, sub_next;
    logic [4:0]  word_reg, word_next;
    logic [31:0] asm_reg;
    logic [23:0] flag_reg;
    logic [15:0] hdr_addr_reg;
    logic        step_reg;
    logic [23:0] exp_reg;
    logic        gap_reg;
    logic        wr_bank_reg;
    logic        rd_bank_reg;
    logic [1:0]  busy_reg, busy_next;
    logic [31:0] bank_flags_reg [2];
    logic        bank_gap_reg [2];

    logic [4:0]  rd_idx_reg;
    logic        s1_valid_reg;
    logic [1:0]  s1_code_reg;
    logic        s1_gap_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    logic signed [15:0] out_s0_reg, out_s1_reg, out_s2_reg, out_s3_reg;
    logic        out_gap_reg;
    logic        out_last_reg;

    logic        byte_acc;
    logic        in_group;
    logic        is_data;
    logic        grp_done;
    logic        advance;
    logic        rd_done;
    logic [23:0] full_addr;
    logic [4:0]  code_sel;
    logic [39:0] rdata;

    sbu_pkg::ram_wr_t ram_wr;
    sbu_pkg::ram_rd_t ram_rd;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == sbu_pkg::REG_USE_SCALE_FLAGS) ? {31'd0, use_flags_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_flags_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == sbu_pkg::REG_USE_SCALE_FLAGS)
        begin
            use_flags_reg <= pwdata[0];
        end
    end

    // input side
    assign byte_stall = busy_reg[wr_bank_reg];
    assign byte_acc   = byte_valid && !byte_stall;
    assign pos_cur    = packet_start ? 10'd0 : pos_reg;
    assign in_group   = (pos_cur >= sbu_pkg::POS_GRP_FIRST) && (pos_cur < sbu_pkg::POS_GRP_END);
    assign is_data    = off_reg < sbu_pkg::OFF_DATA_END;
    assign grp_done   = byte_acc && in_group && !is_data && off_reg[1:0] == sbu_pkg::FLAG_LAST;
    assign full_addr  = {data_byte, hdr_addr_reg};
    assign pos_next   = pos_cur + 10'd1;

    always_comb
    begin
        off_next  = off_reg;
        sub_next  = sub_reg;
        word_next = word_reg;
        if (pos_cur == sbu_pkg::POS_HDR_LAST)
        begin
            off_next  = 8'd0;
            sub_next  = 3'd0;
            word_next = 5'd0;
        end
        else if (in_group)
        begin
            if (off_reg == sbu_pkg::OFF_LAST)
            begin
                off_next  = 8'd0;
                sub_next  = 3'd0;
                word_next = 5'd0;
            end
            else
            begin
                off_next = off_reg + 8'd1;
                if (is_data)
                begin
                    if (sub_reg == sbu_pkg::SUB_LAST)
                    begin
                        sub_next  = 3'd0;
                        word_next = word_reg + 5'd1;
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 10'd0;
            off_reg      <= 8'd0;
            sub_reg      <= 3'd0;
            word_reg     <= 5'd0;
            hdr_addr_reg <= 16'd0;
            step_reg     <= 1'b0;
            exp_reg      <= 24'd0;
            gap_reg      <= 1'b0;
            wr_bank_reg  <= 1'b0;
        end
        else if (byte_acc)
        begin
            pos_reg  <= pos_next;
            off_reg  <= off_next;
            sub_reg  <= sub_next;
            word_reg <= word_next;
            unique case (pos_cur)
                sbu_pkg::POS_STEP_BYTE: step_reg <= data_byte[7];
                sbu_pkg::POS_ADDR_LO:   hdr_addr_reg[7:0] <= data_byte;
                sbu_pkg::POS_ADDR_MID:  hdr_addr_reg[15:8] <= data_byte;
                sbu_pkg::POS_ADDR_HI:
                begin
                    gap_reg <= (full_addr != exp_reg);
                    exp_reg <= full_addr + {23'd0, step_reg} + 24'd1;
                end
                default: ;
            endcase
            if (grp_done)
            begin
                wr_bank_reg <= !wr_bank_reg;
            end
        end
    end

    // group payload holding
    always_ff @(posedge clk)
    begin
        if (byte_acc && in_group)
        begin
            if (is_data)
            begin
                if (sub_reg != sbu_pkg::SUB_LAST)
                begin
                    asm_reg[8*sub_reg[1:0] +: 8] <= data_byte;
                end
            end
            else if (off_reg[1:0] != sbu_pkg::FLAG_LAST)
            begin
                flag_reg[8*off_reg[1:0] +: 8] <= data_byte;
            end
            else
            begin
                bank_flags_reg[wr_bank_reg] <= {data_byte, flag_reg};
                bank_gap_reg[wr_bank_reg]   <= gap_reg;
            end
        end
    end

    always_comb
    begin
        ram_wr.en   = byte_acc && in_group && is_data && sub_reg == sbu_pkg::SUB_LAST;
        ram_wr.addr = {wr_bank_reg, word_reg};
        ram_wr.data = {data_byte, asm_reg};
    end

    // output side
    assign advance  = !out_valid_reg || !result_stall;
    assign code_sel = {rd_idx_reg[4:1], 1'b0};
    assign rd_done  = ram_rd.en && rd_idx_reg == sbu_pkg::IDX_LAST;

    always_comb
    begin
        ram_rd.en   = busy_reg[rd_bank_reg] && (!s1_valid_reg || advance);
        ram_rd.addr = {rd_bank_reg, rd_idx_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (grp_done)
        begin
            busy_next[wr_bank_reg] = 1'b1;
        end
        if (rd_done)
        begin
            busy_next[rd_bank_reg] = 1'b0;
        end
    end

    sbu_group_ram u_group_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 2'b00;
            rd_bank_reg   <= 1'b0;
            rd_idx_reg    <= 5'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (ram_rd.en)
            begin
                rd_idx_reg   <= rd_idx_reg + 5'd1;
                s1_valid_reg <= 1'b1;
                if (rd_done)
                begin
                    rd_bank_reg <= !rd_bank_reg;
                end
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_rd.en)
        begin
            s1_code_reg <= use_flags_reg ? bank_flags_reg[rd_bank_reg][code_sel +: 2]
                                         : sbu_pkg::CODE_SHIFT2;
            s1_gap_reg  <= bank_gap_reg[rd_bank_reg];
            s1_last_reg <= rd_idx_reg == sbu_pkg::IDX_LAST;
        end
        if (advance && s1_valid_reg)
        begin
            out_s0_reg   <= scale_sample({rdata[9:8], rdata[7:0], 6'd0}, s1_code_reg);
            out_s1_reg   <= scale_sample({rdata[19:16], rdata[15:10], 6'd0}, s1_code_reg);
            out_s2_reg   <= scale_sample({rdata[29:24], rdata[23:20], 6'd0}, s1_code_reg);
            out_s3_reg   <= scale_sample({rdata[39:32], rdata[31:30], 6'd0}, s1_code_reg);
            out_gap_reg  <= s1_gap_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign sample_0      = out_s0_reg;
    assign sample_1      = out_s1_reg;
    assign sample_2      = out_s2_reg;
    assign sample_3      = out_s3_reg;
    assign gap_seen      = out_gap_reg;
    assign last_of_group = out_last_reg;

    `SBU_ASSERT_IMPLY(a_wr_free_bank, clk, rst_n, ram_wr.en, !busy_reg[ram_wr.addr[5]],
                      "write into a bank awaiting output")
    `SBU_ASSERT_IMPLY(a_rd_busy_bank, clk, rst_n, ram_rd.en, busy_reg[ram_rd.addr[5]],
                      "read from a bank with no pending group")
    `SBU_ASSERT_IMPLY(a_no_overlap, clk, rst_n, ram_wr.en && ram_rd.en,
                      ram_wr.addr[5] != ram_rd.addr[5], "read and write share a bank")
    `SBU_ASSERT_NEXT(a_drain_frees, clk, rst_n, rd_done && !rd_bank_reg, !busy_reg[0],
                     "drained bank 0 still busy")
    `SBU_ASSERT_NEXT(a_done_marks, clk, rst_n, grp_done && wr_bank_reg, busy_reg[1],
                     "finished group did not mark bank 1")

endmodule
